FILE: hw/rtl/dog_pkg.sv
package dog_pkg;

    localparam int MAX_WIDTH  = 2048;
    localparam int MAX_HEIGHT = 2048;

    localparam int DIM_W   = 12;
    localparam int COL_W   = $clog2(MAX_WIDTH);
    localparam int ROW_W   = $clog2(MAX_HEIGHT + 3);
    localparam int EMIT_W  = $clog2(MAX_WIDTH * MAX_HEIGHT);
    localparam int TOTAL_W = EMIT_W + 1;
    localparam int POS_W   = EMIT_W + 2;
    localparam int CH_W    = 8;
    localparam int N_CH    = 3;
    localparam int PIX_W   = CH_W * N_CH;
    localparam int BANKS   = 4;
    localparam int BANK_W  = $clog2(BANKS);
    localparam int WIN_N   = 4;

    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 1'b1;

    localparam logic OP_FLUSH = 1'b1;

    localparam logic [DIM_W-1:0]   RESET_WIDTH  = DIM_W'(640);
    localparam logic [DIM_W-1:0]   RESET_HEIGHT = DIM_W'(480);
    localparam logic [TOTAL_W-1:0] RESET_TOTAL  = TOTAL_W'(640 * 480);

    typedef logic [PIX_W-1:0] t_pix;

    typedef struct packed {
        logic last;
        t_pix dog;
    } t_result;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v, input int hi);
        if (v == '0) begin
            return DIM_W'(1);
        end
        if (int'(v) > hi) begin
            return DIM_W'(hi);
        end
        return v;
    endfunction

    function automatic t_pix tap3(input t_pix a, input t_pix b, input t_pix c);
        logic [CH_W+1:0] s;
        t_pix            r;
        r = '0;
        for (int k = 0; k < N_CH; k++) begin
            s = (CH_W+2)'(a[k*CH_W +: CH_W]) + {1'b0, b[k*CH_W +: CH_W], 1'b0}
              + (CH_W+2)'(c[k*CH_W +: CH_W]);
            r[k*CH_W +: CH_W] = s[CH_W+1:2];
        end
        return r;
    endfunction

    function automatic t_pix tap5(input t_pix a, input t_pix b, input t_pix c,
                                  input t_pix d, input t_pix e);
        logic [CH_W+3:0] s;
        t_pix            r;
        r = '0;
        for (int k = 0; k < N_CH; k++) begin
            s = (CH_W+4)'(a[k*CH_W +: CH_W])
              + {2'b0, b[k*CH_W +: CH_W], 2'b0}
              + (CH_W+4)'(c[k*CH_W +: CH_W]) * (CH_W+4)'(6)
              + {2'b0, d[k*CH_W +: CH_W], 2'b0}
              + (CH_W+4)'(e[k*CH_W +: CH_W]);
            r[k*CH_W +: CH_W] = s[CH_W+3:4];
        end
        return r;
    endfunction

    function automatic t_pix sel4(input t_pix d0, input t_pix d1, input t_pix d2,
                                  input t_pix d3, input logic [BANK_W-1:0] s);
        t_pix r;
        case (s)
            2'd0:    r = d0;
            2'd1:    r = d1;
            2'd2:    r = d2;
            default: r = d3;
        endcase
        return r;
    endfunction

endpackage

FILE: hw/rtl/difference_of_gaussian_filter.sv
// Channel   Direction  Content
// s_axis    in         tdata: in_ch0, in_ch1, in_ch2; tuser: op (1 = flush)
// m_axis    out        tdata: dog_ch0, dog_ch1, dog_ch2; tlast: frame_last
// cfg       in         i_cfg_index 0 image_width, 1 image_height, i_cfg_data
//
// One request per cycle while s_axis_tready is high. A result passes through the line-store read stage
// and a three-entry output queue.
// A register write drops s_axis_tready while one multiply, one add and a 22-step divide
// of the emitted count by the width rebuild the raster counters.
// Reset clears counters and window; line stores are not cleared.
// Output stalls back up through the queue into s_axis_tready.
module difference_of_gaussian_filter (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_wr_en,
    input  logic [dog_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [dog_pkg::DIM_W-1:0]          i_cfg_data,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  dog_pkg::t_pix                      s_axis_tdata,   // in_ch0, in_ch1, in_ch2
    input  logic                               s_axis_tuser,   // op
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output dog_pkg::t_pix                      m_axis_tdata,   // dog_ch0, dog_ch1, dog_ch2
    output logic                               m_axis_tlast
);
    import dog_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MUL  = 2'd1;
    localparam logic [1:0] ST_ADD  = 2'd2;
    localparam logic [1:0] ST_DIV  = 2'd3;

    localparam int DIV_CNT_W   = $clog2(EMIT_W);
    localparam int QUEUE_DEPTH = 3;
    localparam int QPTR_W      = 2;

    logic [1:0]           r_state, n_state;
    logic [DIV_CNT_W-1:0] r_div_cnt, n_div_cnt;
    logic [DIM_W-1:0]     r_rem, n_rem;
    logic [ROW_W-1:0]     r_quo, n_quo;
    logic [POS_W-1:0]     r_prod, n_prod;
    logic [TOTAL_W-1:0]   r_total, n_total;
    logic [DIM_W-1:0]     r_w, n_w;
    logic [DIM_W-1:0]     r_h, n_h;
    logic [COL_W-1:0]     r_c, n_c;
    logic [ROW_W-1:0]     r_r, n_r;
    logic [POS_W-1:0]     r_p, n_p;
    logic [EMIT_W-1:0]    r_e, n_e;
    logic [COL_W-1:0]     r_oc_c, n_oc_c;
    logic [ROW_W-1:0]     r_oc_r, n_oc_r;
    t_pix                 r_win [WIN_N];
    t_pix                 n_win [WIN_N];

    logic                 acc;
    logic                 restart;
    logic [COL_W-1:0]     c0, occ0;
    logic [ROW_W-1:0]     r0, or0;
    logic [POS_W-1:0]     p0;
    logic [EMIT_W-1:0]    e0;
    t_pix                 w0, w1, w2, w3, px;
    t_pix                 h3, h5;
    logic [POS_W-1:0]     thr;
    logic                 emit, last_flag, small_in, large_in;
    logic                 wr_s, wr_l, fwd;
    logic [BANK_W-1:0]    bank_w;
    logic [COL_W-1:0]     addr_s, addr_l;
    logic [TOTAL_W-1:0]   e_inc;
    logic                 c_wrap, oc_wrap;
    logic [ROW_W+DIM_W-1:0] mul_rw, mul_wh;
    logic [DIM_W:0]       rem_sh;
    logic                 div_bit;
    logic [DIM_W-1:0]     div_rem;

    t_pix                 r_rd_s [BANKS];
    t_pix                 r_rd_l [BANKS];

    logic                 r_s1_valid;
    logic                 r_s1_small, r_s1_large, r_s1_fwd, r_s1_last;
    logic [BANK_W-1:0]    r_s1_row;
    t_pix                 r_s1_h5;
    t_pix                 sv, lv, lg0, dog;

    t_result              r_q_data [QUEUE_DEPTH];
    logic [QPTR_W-1:0]    r_q_wr, r_q_rd, r_q_count;
    logic                 pop;

    // request side
    assign s_axis_tready = (r_state == ST_IDLE) && !i_cfg_wr_en
                        && ((3'(r_q_count) + 3'(r_s1_valid)) <= 3'(QUEUE_DEPTH - 1));
    assign acc = s_axis_tvalid && s_axis_tready;

    assign restart = (POS_W'(r_c) >= POS_W'(r_w)) || (TOTAL_W'(r_e) >= r_total);
    assign c0   = restart ? '0 : r_c;
    assign r0   = restart ? '0 : r_r;
    assign p0   = restart ? '0 : r_p;
    assign e0   = restart ? '0 : r_e;
    assign occ0 = restart ? '0 : r_oc_c;
    assign or0  = restart ? '0 : r_oc_r;
    assign w0   = restart ? '0 : r_win[0];
    assign w1   = restart ? '0 : r_win[1];
    assign w2   = restart ? '0 : r_win[2];
    assign w3   = restart ? '0 : r_win[3];
    assign px   = (s_axis_tuser == OP_FLUSH) ? '0 : s_axis_tdata;

    assign h3 = tap3(w2, w3, px);
    assign h5 = tap5(w0, w1, w2, w3, px);

    assign thr       = POS_W'({r_w, 1'b0}) + POS_W'(2);
    assign emit      = p0 >= thr;
    assign e_inc     = TOTAL_W'(e0) + TOTAL_W'(1);
    assign last_flag = emit && (e_inc >= r_total);

    assign small_in = (POS_W'(or0) >= POS_W'(1)) && (POS_W'(or0) + POS_W'(2) <= POS_W'(r_h))
                   && (POS_W'(occ0) >= POS_W'(1)) && (POS_W'(occ0) + POS_W'(2) <= POS_W'(r_w));
    assign large_in = (POS_W'(or0) >= POS_W'(2)) && (POS_W'(or0) + POS_W'(3) <= POS_W'(r_h))
                   && (POS_W'(occ0) >= POS_W'(2)) && (POS_W'(occ0) + POS_W'(3) <= POS_W'(r_w));

    assign wr_s   = c0 >= COL_W'(2);
    assign wr_l   = c0 >= COL_W'(4);
    assign bank_w = r0[BANK_W-1:0];
    assign addr_s = c0 - COL_W'(1);
    assign addr_l = c0 - COL_W'(2);
    // the large-blur bottom row is the entry written by this same request
    assign fwd    = wr_l && (bank_w == BANK_W'(or0[BANK_W-1:0] + BANK_W'(2)))
                 && (addr_l == occ0);

    assign c_wrap  = POS_W'(c0) + POS_W'(1) >= POS_W'(r_w);
    assign oc_wrap = POS_W'(occ0) + POS_W'(1) >= POS_W'(r_w);

    assign mul_rw = r_r * r_w;
    assign mul_wh = r_w * r_h;

    assign rem_sh  = {r_rem, r_e[r_div_cnt]};
    assign div_bit = rem_sh >= {1'b0, r_w};
    assign div_rem = div_bit ? DIM_W'(rem_sh - {1'b0, r_w}) : DIM_W'(rem_sh);

    always_comb begin
        n_state   = r_state;
        n_div_cnt = r_div_cnt;
        n_rem     = r_rem;
        n_quo     = r_quo;
        n_prod    = r_prod;
        n_total   = r_total;
        n_w       = r_w;
        n_h       = r_h;
        n_c       = r_c;
        n_r       = r_r;
        n_p       = r_p;
        n_e       = r_e;
        n_oc_c    = r_oc_c;
        n_oc_r    = r_oc_r;
        n_win     = r_win;
        if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                REG_WIDTH:  n_w = clamp_dim(i_cfg_data, MAX_WIDTH);
                REG_HEIGHT: n_h = clamp_dim(i_cfg_data, MAX_HEIGHT);
                default:    ;
            endcase
            n_state = ST_MUL;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (acc) begin
                        if (last_flag) begin
                            n_c    = '0;
                            n_r    = '0;
                            n_p    = '0;
                            n_e    = '0;
                            n_oc_c = '0;
                            n_oc_r = '0;
                            for (int k = 0; k < WIN_N; k++) begin
                                n_win[k] = '0;
                            end
                        end else begin
                            n_win[0] = w1;
                            n_win[1] = w2;
                            n_win[2] = w3;
                            n_win[3] = px;
                            n_c = c_wrap ? '0 : c0 + COL_W'(1);
                            n_r = c_wrap ? r0 + ROW_W'(1) : r0;
                            n_p = p0 + POS_W'(1);
                            if (emit) begin
                                n_e    = EMIT_W'(e_inc);
                                n_oc_c = oc_wrap ? '0 : occ0 + COL_W'(1);
                                n_oc_r = oc_wrap ? or0 + ROW_W'(1) : or0;
                            end else begin
                                n_e    = e0;
                                n_oc_c = occ0;
                                n_oc_r = or0;
                            end
                        end
                    end
                end
                ST_MUL: begin
                    n_prod    = POS_W'(mul_rw);
                    n_total   = TOTAL_W'(mul_wh);
                    n_rem     = '0;
                    n_quo     = '0;
                    n_div_cnt = DIV_CNT_W'(EMIT_W - 1);
                    n_state   = ST_ADD;
                end
                ST_ADD: begin
                    n_p     = r_prod + POS_W'(r_c);
                    n_state = ST_DIV;
                end
                ST_DIV: begin
                    n_rem = div_rem;
                    n_quo = {r_quo[ROW_W-2:0], div_bit};
                    if (r_div_cnt == '0) begin
                        n_oc_r  = {r_quo[ROW_W-2:0], div_bit};
                        n_oc_c  = COL_W'(div_rem);
                        n_state = ST_IDLE;
                    end else begin
                        n_div_cnt = r_div_cnt - DIV_CNT_W'(1);
                    end
                end
                default: n_state = ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_total <= RESET_TOTAL;
            r_w     <= RESET_WIDTH;
            r_h     <= RESET_HEIGHT;
            r_c     <= '0;
            r_r     <= '0;
            r_p     <= '0;
            r_e     <= '0;
            r_oc_c  <= '0;
            r_oc_r  <= '0;
            for (int k = 0; k < WIN_N; k++) begin
                r_win[k] <= '0;
            end
        end else begin
            r_state <= n_state;
            r_total <= n_total;
            r_w     <= n_w;
            r_h     <= n_h;
            r_c     <= n_c;
            r_r     <= n_r;
            r_p     <= n_p;
            r_e     <= n_e;
            r_oc_c  <= n_oc_c;
            r_oc_r  <= n_oc_r;
            r_win   <= n_win;
        end
    end

    always_ff @(posedge i_clk) begin
        r_div_cnt <= n_div_cnt;
        r_rem     <= n_rem;
        r_quo     <= n_quo;
        r_prod    <= n_prod;
    end

    // line stores: one bank per row modulo four, all banks read at the output column
    for (genvar g = 0; g < BANKS; g++) begin : g_bank
        t_pix r_mem_s [MAX_WIDTH];
        t_pix r_mem_l [MAX_WIDTH];

        always_ff @(posedge i_clk) begin
            if (acc && wr_s && (bank_w == BANK_W'(g))) begin
                r_mem_s[addr_s] <= h3;
            end
            if (acc && wr_l && (bank_w == BANK_W'(g))) begin
                r_mem_l[addr_l] <= h5;
            end
            r_rd_s[g] <= r_mem_s[occ0];
            r_rd_l[g] <= r_mem_l[occ0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= acc && emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_s1_small <= small_in;
            r_s1_large <= large_in;
            r_s1_fwd   <= fwd;
            r_s1_last  <= last_flag;
            r_s1_row   <= or0[BANK_W-1:0];
            r_s1_h5    <= h5;
        end
    end

    always_comb begin
        sv = '0;
        lv = '0;
        lg0 = sel4(r_rd_l[0], r_rd_l[1], r_rd_l[2], r_rd_l[3], r_s1_row - BANK_W'(2));
        if (r_s1_small) begin
            sv = tap3(sel4(r_rd_s[0], r_rd_s[1], r_rd_s[2], r_rd_s[3], r_s1_row - BANK_W'(1)),
                      sel4(r_rd_s[0], r_rd_s[1], r_rd_s[2], r_rd_s[3], r_s1_row),
                      sel4(r_rd_s[0], r_rd_s[1], r_rd_s[2], r_rd_s[3], r_s1_row + BANK_W'(1)));
        end
        if (r_s1_large) begin
            lv = tap5(lg0,
                      sel4(r_rd_l[0], r_rd_l[1], r_rd_l[2], r_rd_l[3], r_s1_row - BANK_W'(1)),
                      sel4(r_rd_l[0], r_rd_l[1], r_rd_l[2], r_rd_l[3], r_s1_row),
                      sel4(r_rd_l[0], r_rd_l[1], r_rd_l[2], r_rd_l[3], r_s1_row + BANK_W'(1)),
                      r_s1_fwd ? r_s1_h5 : lg0);
        end
        for (int k = 0; k < N_CH; k++) begin
            dog[k*CH_W +: CH_W] = sv[k*CH_W +: CH_W] - lv[k*CH_W +: CH_W];
        end
    end

    // output queue
    assign pop = m_axis_tvalid && m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q_wr    <= '0;
            r_q_rd    <= '0;
            r_q_count <= '0;
        end else begin
            if (r_s1_valid) begin
                r_q_wr <= (r_q_wr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_q_wr + QPTR_W'(1);
            end
            if (pop) begin
                r_q_rd <= (r_q_rd == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_q_rd + QPTR_W'(1);
            end
            r_q_count <= r_q_count + QPTR_W'(r_s1_valid) - QPTR_W'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s1_valid) begin
            r_q_data[r_q_wr] <= '{last: r_s1_last, dog: dog};
        end
    end

    assign m_axis_tvalid = r_q_count != '0;
    assign m_axis_tdata  = r_q_data[r_q_rd].dog;
    assign m_axis_tlast  = r_q_data[r_q_rd].last;

`ifndef ASSERT_OFF
    a_queue_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_q_count == QPTR_W'(QUEUE_DEPTH)) |-> !r_s1_valid)
        else $error("output queue full while a result is pushed");

    a_out_col: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> (POS_W'(r_oc_c) < POS_W'(r_w)))
        else $error("output column outside the row");

    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && last_flag) |=> (r_e == '0 && r_c == '0 && r_p == '0))
        else $error("frame end did not clear the raster counters");
`endif

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import dog_pkg::*;

    localparam logic        OP_PIXEL   = ~OP_FLUSH;
    localparam int unsigned STALL_LIMIT = 5000;
    localparam int unsigned HOLD_CYCLES = 300;
    localparam int unsigned RANDOM_REQS = 900;

    class dog_scoreboard;
        t_pix             small_rows[BANKS*MAX_WIDTH];
        t_pix             large_rows[BANKS*MAX_WIDTH];
        t_pix             window[5];
        int unsigned      col;
        int unsigned      row;
        int unsigned      emitted;
        logic [DIM_W-1:0] width_reg;
        logic [DIM_W-1:0] height_reg;
        t_result          pending_dog[$];
        int unsigned      errors;

        function new();
            foreach (small_rows[i]) begin
                small_rows[i] = '0;
                large_rows[i] = '0;
            end
            width_reg  = RESET_WIDTH;
            height_reg = RESET_HEIGHT;
            errors     = 0;
            rewind();
        endfunction

        function void rewind();
            col     = 0;
            row     = 0;
            emitted = 0;
            foreach (window[i]) window[i] = '0;
        endfunction

        function int unsigned effective(logic [DIM_W-1:0] v, int unsigned hi);
            if (v == '0) return 1;
            if (v > hi) return hi;
            return 32'(v);
        endfunction

        function int unsigned frame_pixels();
            return effective(width_reg, MAX_WIDTH) * effective(height_reg, MAX_HEIGHT);
        endfunction

        function bit at_frame_start();
            return col == 0 && row == 0 && emitted == 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [DIM_W-1:0] value);
            if (idx == REG_WIDTH) begin
                width_reg = value;
            end else begin
                height_reg = value;
            end
        endfunction

        function int unsigned slot(int unsigned r, int unsigned c);
            return (r % BANKS) * MAX_WIDTH + c;
        endfunction

        function t_pix smooth3(t_pix a, t_pix b, t_pix c);
            t_pix r;
            int   s;
            r = '0;
            for (int k = 0; k < N_CH; k++) begin
                s = int'(a[k*CH_W +: CH_W]) + 2 * int'(b[k*CH_W +: CH_W])
                  + int'(c[k*CH_W +: CH_W]);
                r[k*CH_W +: CH_W] = CH_W'(s / 4);
            end
            return r;
        endfunction

        function t_pix smooth5(t_pix a, t_pix b, t_pix c, t_pix d, t_pix e);
            t_pix r;
            int   s;
            r = '0;
            for (int k = 0; k < N_CH; k++) begin
                s = int'(a[k*CH_W +: CH_W]) + 4 * int'(b[k*CH_W +: CH_W])
                  + 6 * int'(c[k*CH_W +: CH_W]) + 4 * int'(d[k*CH_W +: CH_W])
                  + int'(e[k*CH_W +: CH_W]);
                r[k*CH_W +: CH_W] = CH_W'(s / 16);
            end
            return r;
        endfunction

        function void step_raster(int unsigned w);
            col++;
            if (col >= w) begin
                col = 0;
                row++;
            end
        endfunction

        function void note_request(logic op, t_pix pix);
            int unsigned w, h, total, c, r, er, ec;
            t_pix        px, sv, lv;
            t_pix        tall[4];
            bit          emit, small_in, large_in;
            t_result     res;
            w     = effective(width_reg, MAX_WIDTH);
            h     = effective(height_reg, MAX_HEIGHT);
            total = w * h;
            if (col >= w || emitted >= total) rewind();
            c  = col;
            r  = row;
            px = (op == OP_FLUSH) ? '0 : pix;
            for (int k = 0; k < 4; k++) window[k] = window[k+1];
            window[4] = px;
            emit = (longint'(r) * w + c >= 2 * longint'(w) + 2);
            sv = '0;
            lv = '0;
            small_in = 0;
            large_in = 0;
            er = 0;
            ec = 0;
            foreach (tall[i]) tall[i] = '0;
            if (emit) begin
                er = emitted / w;
                ec = emitted % w;
                small_in = er >= 1 && er + 2 <= h && ec >= 1 && ec + 2 <= w;
                large_in = er >= 2 && er + 3 <= h && ec >= 2 && ec + 3 <= w;
                if (small_in) begin
                    sv = smooth3(small_rows[slot(er - 1, ec)], small_rows[slot(er, ec)],
                                 small_rows[slot(er + 1, ec)]);
                end
                if (large_in) begin
                    for (int k = 0; k < 4; k++) tall[k] = large_rows[slot(er - 2 + k, ec)];
                end
            end
            if (c >= 2 && c + 1 <= w) begin
                small_rows[slot(r, c - 1)] = smooth3(window[2], window[3], window[4]);
            end
            if (c >= 4 && c + 1 <= w) begin
                large_rows[slot(r, c - 2)] = smooth5(window[0], window[1], window[2],
                                                     window[3], window[4]);
            end
            if (!emit) begin
                step_raster(w);
                return;
            end
            if (large_in) begin
                lv = smooth5(tall[0], tall[1], tall[2], tall[3],
                             large_rows[slot(er + 2, ec)]);
            end
            for (int k = 0; k < N_CH; k++) begin
                res.dog[k*CH_W +: CH_W] = sv[k*CH_W +: CH_W] - lv[k*CH_W +: CH_W];
            end
            emitted++;
            res.last = (emitted >= total);
            if (res.last) begin
                rewind();
            end else begin
                step_raster(w);
            end
            pending_dog.push_back(res);
        endfunction

        function void check_result(t_pix dog, logic last);
            t_result want;
            if (pending_dog.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, expected none, actual dog=%h last=%b",
                         $time, dog, last);
                return;
            end
            want = pending_dog.pop_front();
            for (int k = 0; k < N_CH; k++) begin
                if (want.dog[k*CH_W +: CH_W] !== dog[k*CH_W +: CH_W]) begin
                    errors++;
                    $display("%0t: dog_ch%0d mismatch, expected %h actual %h", $time, k,
                             want.dog[k*CH_W +: CH_W], dog[k*CH_W +: CH_W]);
                end
            end
            if (want.last !== last) begin
                errors++;
                $display("%0t: frame_last mismatch, expected %b actual %b", $time,
                         want.last, last);
            end
        endfunction
    endclass

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_cfg_wr_en;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [DIM_W-1:0]     i_cfg_data;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    t_pix                 s_axis_tdata;
    logic                 s_axis_tuser;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    t_pix                 m_axis_tdata;
    logic                 m_axis_tlast;

    dog_scoreboard sb = new();
    int unsigned   stall_pct = 18;
    bit            hold_off_req = 1'b0;
    int unsigned   sent_requests = 0;
    int unsigned   quiet_cycles = 0;

    difference_of_gaussian_filter u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #5 i_clk = ~i_clk;

    task automatic send_request(input logic op, input t_pix pix);
        while ($urandom_range(0, 99) < stall_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= pix;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sb.note_request(op, pix);
        sent_requests++;
    endtask

    task automatic close_frame();
        while (!sb.at_frame_start()) send_request(OP_FLUSH, t_pix'($urandom()));
    endtask

    task automatic send_frame(input bit well_formed);
        int unsigned n;
        if (well_formed) begin
            n = sb.frame_pixels();
            repeat (n) send_request(OP_PIXEL, t_pix'($urandom()));
        end else begin
            n = $urandom_range(1, sb.frame_pixels() * 2 + 6);
            repeat (n) begin
                send_request(($urandom_range(0, 3) == 0) ? OP_FLUSH : OP_PIXEL,
                             t_pix'($urandom()));
            end
        end
        close_frame();
    endtask

    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (sb.pending_dog.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic program_size(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= REG_WIDTH;
        i_cfg_data  <= w;
        @(posedge i_clk);
        sb.set_reg(REG_WIDTH, w);
        i_cfg_index <= REG_HEIGHT;
        i_cfg_data  <= h;
        @(posedge i_clk);
        sb.set_reg(REG_HEIGHT, h);
        i_cfg_wr_en <= 1'b0;
    endtask

    // receiver: check, then pick tready, with one long hold-off on request
    initial begin
        int unsigned hold_left;
        hold_left     = 0;
        m_axis_tready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
                sb.check_result(m_axis_tdata, m_axis_tlast);
            end
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                hold_left    = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        t_pix             board[9];
        int unsigned      rand_start, nframes;
        logic [DIM_W-1:0] cfg_w, cfg_h;
        bit               pressure_done;
        board = '{24'hFFFFFF, 24'h000000, 24'hFFFFFF, 24'h000000, 24'hFF00FF,
                  24'h000000, 24'hFFFFFF, 24'h000000, 24'hFFFFFF};
        pressure_done = 1'b0;
        i_rst_n       = 1'b0;
        i_cfg_wr_en   = 1'b0;
        i_cfg_index   = REG_WIDTH;
        i_cfg_data    = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = OP_PIXEL;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // single pixel frame: early flush, then a fill pixel
        program_size(12'd1, 12'd1);
        send_request(OP_FLUSH, 24'hFFFFFF);
        send_request(OP_PIXEL, 24'hFFFFFF);
        close_frame();
        settle();

        program_size(12'd3, 12'd3);
        foreach (board[i]) send_request(OP_PIXEL, board[i]);
        close_frame();
        settle();

        // out-of-range and extreme sizes; cut the large frames short and restart
        program_size(12'd0, 12'd0);
        repeat (3) send_frame($urandom_range(0, 1));
        settle();
        program_size(12'hFFF, 12'd1);
        repeat (24) send_request(OP_PIXEL, t_pix'($urandom()));
        settle();
        program_size(12'd1, 12'hFFF);
        repeat (40) send_request(OP_PIXEL, t_pix'($urandom()));
        settle();
        program_size(12'd1, 12'd1);
        close_frame();
        settle();

        rand_start = sent_requests;
        while (sent_requests - rand_start < RANDOM_REQS) begin
            cfg_w = ($urandom_range(0, 9) == 0) ? 12'd0 : DIM_W'($urandom_range(1, 12));
            cfg_h = ($urandom_range(0, 9) == 0) ? 12'd0 : DIM_W'($urandom_range(1, 10));
            stall_pct = (sent_requests - rand_start >= 400 &&
                         sent_requests - rand_start < 700) ? 0 : 18;
            settle();
            if (!pressure_done && sent_requests - rand_start >= 150) begin
                cfg_w         = 12'd8;
                cfg_h         = 12'd6;
                pressure_done = 1'b1;
                hold_off_req  = 1'b1;
            end
            program_size(cfg_w, cfg_h);
            nframes = $urandom_range(1, 3);
            repeat (nframes) send_frame($urandom_range(0, 3) != 0);
        end

        s_axis_tvalid <= 1'b0;
        while (sb.pending_dog.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending_dog.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
